FILE: design/fasmd_pkg.sv
package fasmd_pkg;

    typedef logic signed [10:0] exp_t;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        FLAG_OK    = 2'd0,
        FLAG_OVER  = 2'd1,
        FLAG_UNDER = 2'd2
    } flag_t;

    localparam logic [23:0] HIDDEN_BIT = 24'h800000;
    localparam logic [22:0] FRAC_MASK  = 23'h7FFFFF;
    localparam logic [31:0] SIGN_BIT   = 32'h80000000;
    localparam logic [31:0] INF_BITS   = 32'h7F800000;
    localparam exp_t        EXP_BIAS   = 11'sd127;
    localparam exp_t        EXP_MAX    = 11'sd255;
    localparam logic [4:0]  RECIP_LAST = 5'd25;
    localparam logic [4:0]  MUL_LAST   = 5'd23;
    localparam logic [24:0] RECIP_INIT = 25'h400000;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } fasmd_req_t;

    typedef struct packed {
        logic [31:0] result_bits;
        logic [1:0]  range_flag;
    } fasmd_res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } fasmd_status_t;

endpackage

FILE: design/fasmd_core.sv
module fasmd_core
    import fasmd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  fasmd_req_t    req,
    input  logic          ack,
    output fasmd_status_t status,
    output fasmd_res_t    res
);

    typedef enum logic [3:0] {
        S_IDLE, S_ALIGN, S_ADD, S_RECIP, S_RFIX, S_MUL, S_NORM, S_PACK, S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] a_reg, a_next, b_reg, b_next;
    logic        sign_reg, sign_next, sub_reg, sub_next;
    exp_t        exp_reg, exp_next;
    logic [23:0] m1_reg, m1_next, m2_reg, m2_next, mc_reg, mc_next;
    logic [24:0] wm_reg, wm_next, rem_reg, rem_next;
    logic [47:0] prod_reg, prod_next;
    logic [25:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    fasmd_res_t  res_reg, res_next;

    // shared adder / subtractor
    logic [25:0] alu_a, alu_b, alu_y;
    logic        alu_sub;

    logic [31:0] big, lesser, bsel;
    logic [7:0]  e1, e2, shift, ea, eb;
    logic [23:0] ma, mult;
    logic [26:0] qr_sum;
    logic [25:0] qr;

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_ADD:
            begin
                alu_a   = {2'b00, m1_reg};
                alu_b   = {2'b00, m2_reg};
                alu_sub = sub_reg;
            end
            S_RECIP:
            begin
                alu_a   = {1'b0, rem_reg[23:0], 1'b0};
                alu_b   = {2'b00, mc_reg};
                alu_sub = 1'b1;
            end
            S_MUL:
            begin
                alu_a = {2'b00, prod_reg[47:24]};
                alu_b = prod_reg[0] ? {2'b00, mc_reg} : 26'd0;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
        alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    always_comb
    begin
        bsel   = (req.func == FUNC_SUB) ? (req.operand_b ^ SIGN_BIT) : req.operand_b;
        big    = (b_reg[30:0] > a_reg[30:0]) ? b_reg : a_reg;
        lesser = (b_reg[30:0] > a_reg[30:0]) ? a_reg : b_reg;
        e1     = big[30:23];
        e2     = lesser[30:23];
        shift  = e1 - e2;
        ea     = a_reg[30:23];
        eb     = b_reg[30:23];
        ma     = {1'b1, a_reg[22:0]};
        qr_sum = {1'b0, quo_reg} + 27'd1;
        qr     = qr_sum[26:1];
        mult   = qr[24] ? HIDDEN_BIT : qr[23:0];

        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        sign_next  = sign_reg;
        sub_next   = sub_reg;
        exp_next   = exp_reg;
        m1_next    = m1_reg;
        m2_next    = m2_reg;
        mc_next    = mc_reg;
        wm_next    = wm_reg;
        rem_next   = rem_reg;
        prod_next  = prod_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next = req.operand_a;
                    b_next = bsel;
                    case (req.func)
                        FUNC_ADD, FUNC_SUB: state_next = S_ALIGN;
                        FUNC_MUL:           state_next = S_MUL;
                        default:            state_next = S_RECIP;
                    endcase
                    sign_next = req.operand_a[31] ^ req.operand_b[31];
                    cnt_next  = '0;
                    // multiply starts from the raw operands
                    prod_next = {24'd0, 1'b1, req.operand_b[22:0]};
                    mc_next   = (req.func == FUNC_MUL) ? {1'b1, req.operand_a[22:0]}
                                                       : {1'b1, req.operand_b[22:0]};
                    exp_next  = exp_t'({3'b000, req.operand_a[30:23]})
                              + exp_t'({3'b000, req.operand_b[30:23]}) - EXP_BIAS;
                    rem_next  = RECIP_INIT;
                    quo_next  = '0;
                end
            end
            S_ALIGN:
            begin
                sign_next = big[31];
                sub_next  = big[31] ^ lesser[31];
                exp_next  = exp_t'({3'b000, e1});
                m1_next   = {1'b1, big[22:0]};
                m2_next   = (shift >= 8'd24) ? 24'd0 : ({1'b1, lesser[22:0]} >> shift[4:0]);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                wm_next = alu_y[24:0];
                if (alu_y[24:0] == 25'd0)
                begin
                    // exact cancellation gives plus zero
                    res_next.result_bits = '0;
                    res_next.range_flag  = FLAG_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end
            S_RECIP:
            begin
                quo_next = {quo_reg[24:0], ~alu_y[25]};
                rem_next = alu_y[25] ? alu_a[24:0] : alu_y[24:0];
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == RECIP_LAST)
                begin
                    state_next = S_RFIX;
                end
            end
            S_RFIX:
            begin
                prod_next = {24'd0, mult};
                mc_next   = ma;
                cnt_next  = '0;
                exp_next  = exp_t'({3'b000, ea}) - exp_t'({3'b000, eb})
                          + (qr[24] ? 11'sd127 : 11'sd126);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = {alu_y[24:0], prod_reg[23:1]};
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    wm_next    = alu_y[24:0];
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (wm_reg[24])
                begin
                    wm_next  = {1'b0, wm_reg[24:1]};
                    exp_next = exp_reg + 11'sd1;
                end
                else if (!wm_reg[23])
                begin
                    wm_next  = {wm_reg[23:0], 1'b0};
                    exp_next = exp_reg - 11'sd1;
                end
                else
                begin
                    state_next = S_PACK;
                end
            end
            S_PACK:
            begin
                if (exp_reg >= EXP_MAX)
                begin
                    res_next.result_bits = {sign_reg, 31'd0} | INF_BITS;
                    res_next.range_flag  = FLAG_OVER;
                end
                else if (exp_reg <= 11'sd0)
                begin
                    res_next.result_bits = {sign_reg, 31'd0};
                    res_next.range_flag  = FLAG_UNDER;
                end
                else
                begin
                    res_next.result_bits = {sign_reg, exp_reg[7:0], wm_reg[22:0] & FRAC_MASK};
                    res_next.range_flag  = FLAG_OK;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            sign_reg  <= sign_next;
            sub_reg   <= sub_next;
            exp_reg   <= exp_next;
            m1_reg    <= m1_next;
            m2_reg    <= m2_next;
            mc_reg    <= mc_next;
            wm_reg    <= wm_next;
            rem_reg   <= rem_next;
            prod_reg  <= prod_next;
            quo_reg   <= quo_next;
            res_reg   <= res_next;
        end
    end

    assign status.idle = (state_reg == S_IDLE);
    assign status.done = (state_reg == S_DONE);
    assign res         = res_reg;

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_RECIP) |-> cnt_reg <= RECIP_LAST)
        else $error("step counter ran past its last step");

    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NORM) |-> wm_reg != 25'd0)
        else $error("normalize entered with zero mantissa");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !ack) |=> (state_reg == S_DONE && $stable(res_reg)))
        else $error("finished result dropped before hand-off");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == S_IDLE)
        else $error("request started while busy");

endmodule

FILE: design/float32_add_sub_mul_div_truncating_top.sv
// Truncating single-precision add / subtract / multiply / divide unit.
//
// Input channel (in_valid, in_stall, in_data): one request carries func and
// two bit patterns. A request is taken at a clock edge with in_valid high and
// in_stall low. in_stall stays high while a request is in progress.
// Output channel (out_valid, out_stall, out_data): one result per request,
// result_bits and range_flag. Hold out_stall high to keep the result waiting.
//
// Steps from accept to out_valid; the add, reciprocal and multiply steps
// share one 26-bit adder:
//   add / subtract: align and add; exact cancellation goes straight to the result,
//                   else normalize, one shift per step, up to 23 left shifts
//   multiply:       24 shift-add steps, then normalize
//   divide:         26 reciprocal steps, then the 24-step multiply
// One request is in progress at a time; the next is taken in the cycle after the
// result reaches the output register.
// A finished result moves to the output register, so the next request is
// taken while the previous result still waits on a stalled receiver; the
// unit then holds its next result until the output register frees up.
// Reset clears the sequencer and the output valid; no request is in flight.
module float32_add_sub_mul_div_truncating_top
    import fasmd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  fasmd_req_t in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output fasmd_res_t out_data
);

    fasmd_status_t status;
    fasmd_res_t    core_res;
    logic          start;
    logic          ack;

    logic          out_valid_reg, out_valid_next;
    fasmd_res_t    out_data_reg, out_data_next;

    // take a request only when the sequencer is free
    assign in_stall = !status.idle;
    assign start    = in_valid && !in_stall;

    // hand a finished result over when the output register is free or draining
    assign ack = status.done && (!out_valid_reg || !out_stall);

    fasmd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (in_data),
        .ack    (ack),
        .status (status),
        .res    (core_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (ack)
        begin
            out_valid_next = 1'b1;
            out_data_next  = core_res;
        end
        else if (!out_stall)
        begin
            // drop the result once taken
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
